### rtl/mapt_pkg.sv
// Package for the MAC address pin table: widths, operation codes, sequencer
// states and the scan status struct. No dependencies.
`default_nettype none

package mapt_pkg;

  localparam int ADDR_W        = 48;
  localparam int OP_W          = 2;
  localparam int ENTRY_CNT_W   = 5;
  localparam int PIN_SLOTS_DEF = 16;
  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  // Register index of enforce_pins (word index, paddr[2]).
  localparam logic REG_ENFORCE_IDX = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK = 2'd0,
    OP_ADD   = 2'd1,
    OP_CLEAR = 2'd2
  } mapt_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } mapt_state_t;

  // Compare result coming back from the address store in the cycle after a read.
  typedef struct packed {
    logic vld;
    logic hit;
  } mapt_scan_t;

endpackage

`default_nettype wire

### rtl/mac_address_pin_table_top.sv
// Top level of the MAC address pin table: request sequencer, count register,
// enforce_pins register on an APB-style port. Uses mapt_pkg and mapt_store.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   in       | in_valid / in_ready    | in_op, in_peer_addr
//   out      | out_valid / out_ready  | out_ok, out_found, out_entry_count
//   config   | psel, penable, pwrite  | paddr, pwdata, prdata (pready = 1)
//
// A request is handled in steps: one memory read per stored entry, the last read
// data passing the read register to the compare, the scan end being seen, then
// the response state forming the result and writing back. The single memory read
// port reads the entries one at a time; the next request is taken only once the
// sequencer has returned to its idle state from the response state.
// Reset (rst_n low, synchronous) empties the table and clears enforce_pins;
// the address memory itself is not cleared, entries at or above the count are
// never read. A new request is taken while a result still waits on out; the
// sequencer holds in its response state until the output register frees up.
`default_nettype none

module mac_address_pin_table_top
  import mapt_pkg::*;
#(
  parameter int PIN_SLOTS = PIN_SLOTS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // request channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [OP_W-1:0]        in_op,
  input  wire logic [ADDR_W-1:0]      in_peer_addr,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_ok,
  output logic                        out_found,
  output logic [ENTRY_CNT_W-1:0]      out_entry_count,
  // configuration port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_ADDR_W-1:0]  paddr,
  input  wire logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready
);

  // Index width for the memory, count width able to hold PIN_SLOTS itself.
  localparam int AW = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;
  localparam int CW = $clog2(PIN_SLOTS + 1);

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic enforce_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENFORCE_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enforce_r <= 1'b0;
    end else if (cfg_wr) begin
      enforce_r <= pwdata[0];
    end
  end

  // Byte offset bits paddr[1:0] select nothing: one word per register.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ENFORCE_IDX) begin
      prdata[0] = enforce_r;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  mapt_state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CW-1:0]     sc_r;        // next entry to read
  logic [CW-1:0]     cnt_r;       // number of pinned entries
  logic [CW-1:0]     cnt_nxt;
  logic              found_r;
  logic              out_valid_r;
  logic              ok_r;
  logic              found_q_r;
  logic [ENTRY_CNT_W-1:0] ecnt_r;

  logic       in_acc;
  logic       rd_en;
  logic       scan_done;
  logic       out_free;
  logic       resp_fire;
  logic       wr_en;
  logic       ok_nxt;
  logic       room;
  mapt_scan_t scan;
  logic [CW+ENTRY_CNT_W-1:0] cnt_ext;

  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  // Done once every entry below the count was read and the last compare landed.
  assign scan_done = (sc_r == cnt_r) && !scan.vld;
  assign room      = (cnt_r < CW'(PIN_SLOTS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    resp_fire = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_SCAN: rd_en     = (sc_r < cnt_r);
      ST_RESP: resp_fire = out_free;
      default: ;
    endcase
  end

  // Result of the operation; undefined op changes nothing and answers ok 0.
  always_comb begin
    ok_nxt  = 1'b0;
    cnt_nxt = cnt_r;
    wr_en   = 1'b0;
    case (op_r)
      OP_CHECK: ok_nxt = !enforce_r || found_r;
      OP_ADD: begin
        if (found_r) begin
          ok_nxt = 1'b1;
        end else if (room) begin
          ok_nxt  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          wr_en   = resp_fire;
        end
      end
      OP_CLEAR: begin
        ok_nxt  = 1'b1;
        cnt_nxt = '0;
      end
      default: ;
    endcase
  end

  // entry_count carries the low bits of the count
  assign cnt_ext = {{ENTRY_CNT_W{1'b0}}, cnt_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      sc_r        <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        sc_r    <= '0;
        found_r <= 1'b0;
      end else begin
        if (rd_en) sc_r <= sc_r + CW'(1);
        // accumulate hits as read data comes back
        if (scan.hit) found_r <= 1'b1;
      end
      if (resp_fire) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: capture the request, hold the result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      addr_r <= in_peer_addr;
    end
    if (resp_fire) begin
      ok_r      <= ok_nxt;
      found_q_r <= found_r;
      ecnt_r    <= cnt_ext[ENTRY_CNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = ok_r;
  assign out_found       = found_q_r;
  assign out_entry_count = ecnt_r;

  // ---------------------------------------------------------------------
  // Address store: append at the current count, scan from entry zero
  // ---------------------------------------------------------------------
  mapt_store #(
    .SLOTS (PIN_SLOTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (cnt_r[AW-1:0]),
    .wr_data (addr_r),
    .rd_en   (rd_en),
    .rd_idx  (sc_r[AW-1:0]),
    .key     (addr_r),
    .scan    (scan)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(PIN_SLOTS))
    else $error("pin count exceeds table size");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en && !scan.vld)
    else $error("write back overlaps a scan");

  a_scan_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    scan.vld |-> $past(rd_en))
    else $error("compare result without a read");

  a_resp_shows: assert property (@(posedge clk) disable iff (!rst_n)
    resp_fire |=> out_valid && state_r == ST_IDLE)
    else $error("result not presented after response");

endmodule

`default_nettype wire

### rtl/mapt_store.sv
// Address store of the pin table: one-write, one-read synchronous memory with
// registered read data and a compare against the request key. Uses mapt_pkg.
`default_nettype none

module mapt_store
  import mapt_pkg::*;
#(
  parameter int SLOTS = PIN_SLOTS_DEF,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_idx,
  input  wire logic [ADDR_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_idx,
  input  wire logic [ADDR_W-1:0] key,
  output mapt_scan_t             scan
);

  logic [ADDR_W-1:0] mem [SLOTS];
  logic [ADDR_W-1:0] rd_q_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  assign scan.vld = rd_vld_r;
  assign scan.hit = rd_vld_r && (rd_q_r == key);

endmodule

`default_nettype wire
